>>> rtl/spsg_pkg.sv
package spsg_pkg;

  // Register map of the configuration port.
  typedef enum logic [2:0] {
    REG_PERIOD   = 3'd0,
    REG_MIN      = 3'd1,
    REG_MAX      = 3'd2,
    REG_CENTER   = 3'd3,
    REG_SWEEP    = 3'd4,
    REG_INTERVAL = 3'd5,
    REG_NUDGE    = 3'd6
  } reg_index_t;

  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_INDEX_W = 3;

  // Host command bytes.
  localparam logic [7:0] CMD_UP   = 8'h57;
  localparam logic [7:0] CMD_DOWN = 8'h53;

  // Register reset values.
  localparam logic [15:0] RST_PERIOD   = 16'd50000;
  localparam logic [15:0] RST_MIN      = 16'd1000;
  localparam logic [15:0] RST_MAX      = 16'd5000;
  localparam logic [15:0] RST_CENTER   = 16'd3000;
  localparam logic [7:0]  RST_SWEEP    = 8'd1;
  localparam logic [15:0] RST_INTERVAL = 16'd200;
  localparam logic [11:0] RST_NUDGE    = 12'd100;
  localparam logic [15:0] RST_LOW_LEN  = RST_PERIOD - RST_CENTER;

  typedef struct packed {
    logic [15:0] period_ticks;
    logic [15:0] min_pulse;
    logic [15:0] max_pulse;
    logic [15:0] center_pulse;
    logic [7:0]  sweep_step;
    logic [15:0] sweep_interval;
    logic [11:0] nudge_step;
  } cfg_t;

endpackage

>>> rtl/spsg_cfg.sv
module spsg_cfg
  import spsg_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   we,
  input  logic [CFG_INDEX_W-1:0] index,
  input  logic [CFG_DATA_W-1:0]  data,
  output cfg_t                   cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.period_ticks   <= RST_PERIOD;
      cfg.min_pulse      <= RST_MIN;
      cfg.max_pulse      <= RST_MAX;
      cfg.center_pulse   <= RST_CENTER;
      cfg.sweep_step     <= RST_SWEEP;
      cfg.sweep_interval <= RST_INTERVAL;
      cfg.nudge_step     <= RST_NUDGE;
    end else if (we) begin
      unique case (index)
        REG_PERIOD:   cfg.period_ticks   <= data;
        REG_MIN:      cfg.min_pulse      <= data;
        REG_MAX:      cfg.max_pulse      <= data;
        REG_CENTER:   cfg.center_pulse   <= data;
        REG_SWEEP:    cfg.sweep_step     <= data[7:0];
        REG_INTERVAL: cfg.sweep_interval <= data;
        REG_NUDGE:    cfg.nudge_step     <= data[11:0];
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/servo_pwm_sweep_generator.sv
// Servo PWM generator with automatic sweep and host nudge commands.
// Results are registered: each reaches the master side in the cycle after its input
// transfer. Throughput: one item per cycle while the master side is not stalled;
// the state update and the output register are written on every accepted transfer.
// Reset (synchronous, active high) loads the register defaults and starts in a
// high phase of center_pulse ticks, sweeping toward max_pulse.
module servo_pwm_sweep_generator
  import spsg_pkg::*;
#(
  parameter int unsigned TIME_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [7:0]             s_tdata,   // command_byte
  input  logic                   s_tuser,   // action
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [39:0]            m_tdata    // pin_level, pulse_width, low_time, zero fill
);

  localparam logic [TIME_WIDTH-1:0] TIME_ONE = {{(TIME_WIDTH-1){1'b0}}, 1'b1};

  cfg_t cfg;

  spsg_cfg u_cfg (
    .clk   (clk),
    .rst   (rst),
    .we    (cfg_we),
    .index (cfg_index),
    .data  (cfg_data),
    .cfg   (cfg)
  );

  // Counter reloads keep only the low TIME_WIDTH bits.
  function automatic logic [TIME_WIDTH-1:0] time_load(input logic [15:0] v);
    logic [31:0] wide;
    wide = {16'd0, v};
    return wide[TIME_WIDTH-1:0];
  endfunction

  logic [15:0]           width_now, width_now_next;
  logic                  level_high, level_high_next;
  logic [TIME_WIDTH-1:0] phase_left, phase_left_next;
  logic [15:0]           last_low_len, last_low_len_next;
  logic                  going_up, going_up_next;
  logic [TIME_WIDTH-1:0] sweep_left, sweep_left_next;

  logic        accept;
  logic [15:0] low_len;
  logic [16:0] sweep_sum;
  logic [16:0] nudge_sum;
  logic [15:0] swept;
  logic [15:0] nudged;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    low_len   = (width_now >= cfg.period_ticks) ? 16'd1 : cfg.period_ticks - width_now;
    sweep_sum = {1'b0, width_now} + {9'd0, cfg.sweep_step};
    nudge_sum = {1'b0, width_now} + {5'd0, cfg.nudge_step};

    width_now_next    = width_now;
    level_high_next   = level_high;
    phase_left_next   = phase_left;
    last_low_len_next = last_low_len;
    going_up_next     = going_up;
    sweep_left_next   = sweep_left;
    swept             = width_now;
    nudged            = width_now;

    if (!s_tuser) begin
      // Phase counter first; it sees the width from before the sweep step.
      if (phase_left > TIME_ONE) begin
        phase_left_next = phase_left - TIME_ONE;
      end else if (level_high) begin
        last_low_len_next = low_len;
        level_high_next   = 1'b0;
        phase_left_next   = time_load(low_len);
      end else begin
        level_high_next = 1'b1;
        phase_left_next = time_load(width_now);
      end

      if (sweep_left > TIME_ONE) begin
        sweep_left_next = sweep_left - TIME_ONE;
      end else begin
        sweep_left_next = time_load(cfg.sweep_interval);
        if (going_up) begin
          swept = sweep_sum[16] ? 16'hFFFF : sweep_sum[15:0];
        end else begin
          swept = (width_now > {8'd0, cfg.sweep_step}) ?
                  width_now - {8'd0, cfg.sweep_step} : 16'd0;
        end
        width_now_next = swept;
        if (swept >= cfg.max_pulse) begin
          going_up_next = 1'b0;
        end else if (swept <= cfg.min_pulse) begin
          going_up_next = 1'b1;
        end
      end
    end else begin
      case (s_tdata)
        CMD_UP:   nudged = nudge_sum[16] ? 16'hFFFF : nudge_sum[15:0];
        CMD_DOWN: nudged = (width_now > {4'd0, cfg.nudge_step}) ?
                           width_now - {4'd0, cfg.nudge_step} : 16'd0;
        default:  nudged = width_now;
      endcase
      // The max test wins when the limits are crossed.
      if (nudged >= cfg.max_pulse) begin
        width_now_next = cfg.max_pulse;
      end else if (nudged <= cfg.min_pulse) begin
        width_now_next = cfg.min_pulse;
      end else begin
        width_now_next = nudged;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_now    <= RST_CENTER;
      level_high   <= 1'b1;
      phase_left   <= time_load(RST_CENTER);
      last_low_len <= RST_LOW_LEN;
      going_up     <= 1'b1;
      sweep_left   <= time_load(RST_INTERVAL);
    end else if (accept) begin
      width_now    <= width_now_next;
      level_high   <= level_high_next;
      phase_left   <= phase_left_next;
      last_low_len <= last_low_len_next;
      going_up     <= going_up_next;
      sweep_left   <= sweep_left_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {7'd0, last_low_len_next, width_now_next, level_high_next};
    end
  end

  // The low-phase length is saturated, so it never reads as zero.
  a_low_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    last_low_len != 16'd0)
    else $error("low phase length is zero");

  // Every input transfer leaves a result waiting on the master side.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> m_tvalid)
    else $error("input transfer produced no result");

  // A command byte leaves the width inside sane clamp limits.
  a_clamp: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tuser && !cfg_we && cfg.min_pulse <= cfg.max_pulse) |=>
      (width_now >= cfg.min_pulse && width_now <= cfg.max_pulse))
    else $error("command left width outside clamp limits");

endmodule

>>> tb/tb_servo_pwm_sweep_generator.sv
module tb_servo_pwm_sweep_generator;
  import spsg_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  // Index 7 is not mapped; a write there must leave every register alone.
  localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED = 3'd7;

  typedef struct packed {
    logic       action;
    logic [7:0] cmd;
  } host_item_t;

  typedef struct packed {
    logic        pin;
    logic [15:0] width;
    logic [15:0] low_len;
  } servo_out_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [7:0]             s_tdata = '0;    // command_byte
  logic                   s_tuser = 1'b0;  // action
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [39:0]            m_tdata;         // pin_level, pulse_width, low_time, zero fill

  servo_pwm_sweep_generator dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  host_item_t host_items[$];
  servo_out_t expected_pwm[$];
  host_item_t cur_item;
  servo_out_t want;
  int         items_total = 0;
  int         results_seen = 0;
  int         errors = 0;
  int         settings = 0;
  int         cycles = 0;
  int         src_gap = 0;
  int         sink_gap = 0;
  bit         idling = 1'b1;

  // Predicted registers and state of the servo generator.
  logic [15:0] p_period, p_min, p_max, p_center, p_interval;
  logic [7:0]  p_sweep_step;
  logic [11:0] p_nudge;
  logic [15:0] pw, phase_cnt, low_len, sweep_cnt;
  logic        hi_phase, rising;

  function automatic logic [15:0] low_len_for(logic [15:0] w);
    return (w >= p_period) ? 16'd1 : p_period - w;
  endfunction

  function automatic void reset_model();
    p_period     = RST_PERIOD;
    p_min        = RST_MIN;
    p_max        = RST_MAX;
    p_center     = RST_CENTER;
    p_sweep_step = RST_SWEEP;
    p_interval   = RST_INTERVAL;
    p_nudge      = RST_NUDGE;
    pw           = p_center;
    hi_phase     = 1'b1;
    phase_cnt    = p_center;
    low_len      = low_len_for(p_center);
    rising       = 1'b1;
    sweep_cnt    = p_interval;
  endfunction

  function automatic void apply_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (reg_index_t'(idx))
      REG_PERIOD:   p_period = val;
      REG_MIN:      p_min = val;
      REG_MAX:      p_max = val;
      REG_CENTER:   p_center = val;
      REG_SWEEP:    p_sweep_step = val[7:0];
      REG_INTERVAL: p_interval = val;
      REG_NUDGE:    p_nudge = val[11:0];
      default: ;
    endcase
  endfunction

  function automatic servo_out_t step_servo(logic action, logic [7:0] cmd);
    logic [16:0] sum;
    servo_out_t  res;
    if (!action) begin
      // The phase counter moves first, then the sweep counter.
      if (phase_cnt > 16'd1) begin
        phase_cnt = phase_cnt - 16'd1;
      end else if (hi_phase) begin
        low_len = low_len_for(pw);
        hi_phase = 1'b0;
        phase_cnt = low_len;
      end else begin
        hi_phase = 1'b1;
        phase_cnt = pw;
      end
      if (sweep_cnt > 16'd1) begin
        sweep_cnt = sweep_cnt - 16'd1;
      end else begin
        sweep_cnt = p_interval;
        if (rising) begin
          sum = {1'b0, pw} + p_sweep_step;
          pw = sum[16] ? 16'hFFFF : sum[15:0];
        end else begin
          pw = (pw > p_sweep_step) ? pw - p_sweep_step : 16'd0;
        end
        if (pw >= p_max) rising = 1'b0;
        else if (pw <= p_min) rising = 1'b1;
      end
    end else begin
      if (cmd == CMD_UP) begin
        sum = {1'b0, pw} + p_nudge;
        pw = sum[16] ? 16'hFFFF : sum[15:0];
      end else if (cmd == CMD_DOWN) begin
        pw = (pw > p_nudge) ? pw - p_nudge : 16'd0;
      end
      // The upper limit wins when the limits are crossed.
      if (pw >= p_max) pw = p_max;
      else if (pw <= p_min) pw = p_min;
    end
    res.pin = hi_phase;
    res.width = pw;
    res.low_len = low_len;
    return res;
  endfunction

  // Source side: one item per transfer, with occasional bursts of idle cycles.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (src_gap != 0) begin
        src_gap <= src_gap - 1;
        s_tvalid <= 1'b0;
      end else if (host_items.size() != 0) begin
        cur_item = host_items.pop_front();
        s_tvalid <= 1'b1;
        s_tuser <= cur_item.action;
        s_tdata <= cur_item.cmd;
        if (idling && $urandom_range(0, 11) == 0) src_gap <= $urandom_range(1, 17);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Sink side stalls.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (sink_gap != 0) begin
      sink_gap <= sink_gap - 1;
      m_tready <= 1'b0;
    end else if (idling && $urandom_range(0, 11) == 0) begin
      sink_gap <= $urandom_range(0, 16);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Result check comes before the new prediction so that a stray result is caught.
  always @(posedge clk) begin
    if (rst) begin
      reset_model();
    end else begin
      if (m_tvalid && m_tready) begin
        results_seen = results_seen + 1;
        if (expected_pwm.size() == 0) begin
          $error("result transfer with nothing expected: tdata %h", m_tdata);
          errors++;
        end else begin
          want = expected_pwm.pop_front();
          if (m_tdata[0] !== want.pin) begin
            $error("pin_level: expected %0d, got %0d", want.pin, m_tdata[0]);
            errors++;
          end
          if (m_tdata[16:1] !== want.width) begin
            $error("pulse_width: expected %0d, got %0d", want.width, m_tdata[16:1]);
            errors++;
          end
          if (m_tdata[32:17] !== want.low_len) begin
            $error("low_time: expected %0d, got %0d", want.low_len, m_tdata[32:17]);
            errors++;
          end
        end
      end
      if (cfg_we) apply_reg(cfg_index, cfg_data);
      if (s_tvalid && s_tready) expected_pwm.push_back(step_servo(s_tuser, s_tdata));
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL");
      $finish;
    end
  end

  task automatic queue_item(input logic action, input logic [7:0] cmd);
    host_item_t it;
    it.action = action;
    it.cmd = cmd;
    host_items.push_back(it);
    items_total++;
  endtask

  task automatic queue_random(input int n);
    logic [7:0] cmd;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 3))
        0: cmd = CMD_UP;
        1: cmd = CMD_DOWN;
        default: cmd = 8'($urandom_range(0, 255));
      endcase
      queue_item($urandom_range(0, 9) >= 7, cmd);
    end
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
  endtask

  // Registers are only written once every result of the previous setting is in.
  task automatic program_regs(input logic [15:0] period, input logic [15:0] lo,
                              input logic [15:0] hi, input logic [15:0] ctr,
                              input logic [7:0] st, input logic [15:0] iv,
                              input logic [11:0] nd);
    wait (results_seen == items_total);
    write_reg(REG_PERIOD, period);
    write_reg(REG_MIN, lo);
    write_reg(REG_MAX, hi);
    write_reg(REG_CENTER, ctr);
    write_reg(REG_SWEEP, {8'd0, st});
    write_reg(REG_INTERVAL, iv);
    write_reg(REG_NUDGE, {4'd0, nd});
    @(posedge clk);
    cfg_we <= 1'b0;
    settings++;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Default settings: nudges, non-command bytes, and ticks with odd bytes.
    queue_item(1'b1, CMD_UP);
    queue_item(1'b1, CMD_UP);
    queue_item(1'b1, CMD_DOWN);
    queue_item(1'b1, 8'h00);
    queue_item(1'b1, 8'hFF);
    queue_item(1'b0, 8'hFF);
    queue_item(1'b0, 8'h00);
    queue_item(1'b1, 8'hAA);
    queue_item(1'b0, 8'h55);
    for (int i = 0; i < 40; i++) queue_item(1'b1, CMD_DOWN);
    queue_item(1'b0, CMD_UP);

    // Zero limits: widths collapse to zero and sweeping saturates at zero.
    program_regs(16'd20, 16'd0, 16'd0, 16'd0, 8'd3, 16'd2, 12'd4095);
    queue_item(1'b1, CMD_DOWN);
    queue_item(1'b1, CMD_UP);
    queue_random(70);

    // Top of the range: sweep saturates at full scale, with widths up to the period.
    program_regs(16'd65535, 16'd65535, 16'd65535, 16'd65535, 8'd255, 16'd1, 12'd4095);
    queue_item(1'b1, CMD_UP);
    queue_random(70);

    // Crossed limits: the upper limit takes precedence in the clamp.
    program_regs(16'd100, 16'd80, 16'd20, 16'd50, 8'd7, 16'd5, 12'd9);
    queue_random(70);

    // Shortest period, so widths can reach or pass it.
    program_regs(16'd2, 16'd0, 16'd6, 16'd1, 8'd1, 16'd1, 12'd1);
    queue_random(70);

    // Zero sweep interval and zero steps; the unmapped index is written too.
    program_regs(16'd30, 16'd3, 16'd25, 16'd10, 8'd0, 16'd0, 12'd0);
    write_reg(REG_UNMAPPED, 16'hFFFF);
    @(posedge clk);
    cfg_we <= 1'b0;
    queue_random(70);

    // Longest sweep interval with a short period.
    program_regs(16'd10, 16'd2, 16'd8, 16'd5, 8'd2, 16'd65535, 12'd3);
    queue_random(70);

    for (int ph = 0; ph < 9; ph++) begin
      program_regs(16'($urandom_range(2, 300)), 16'($urandom_range(0, 100)),
                   16'($urandom_range(0, 300)), 16'($urandom_range(0, 65535)),
                   8'($urandom_range(0, 40)), 16'($urandom_range(1, 40)),
                   12'($urandom_range(0, 60)));
      if (ph == 8) idling = 1'b0;
      queue_random(145);
    end

    wait (results_seen == items_total);
    repeat (4) @(posedge clk);
    $display("%0d items sent across %0d register settings, %0d results checked.",
             items_total, settings + 1, results_seen);
    $display("%0d mismatches found.", errors);
    if (errors == 0 && expected_pwm.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
